>>> src/planar_odometry_integrator_macros.svh
// Assertion macros for the planar odometry integrator.
`ifndef PLANAR_ODOMETRY_INTEGRATOR_MACROS_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_MACROS_SVH
`ifndef SYNTHESIS
`define POI_ASSERT(name, clock, rstn, prop, msg) \
    name: assert property (@(posedge clock) disable iff (!rstn) prop) \
        else $error(msg);
`define POI_ASSERT_NORST(name, clock, prop, msg) \
    name: assert property (@(posedge clock) prop) else $error(msg);
`else
`define POI_ASSERT(name, clock, rstn, prop, msg)
`define POI_ASSERT_NORST(name, clock, prop, msg)
`endif
`endif

>>> src/poi_pkg.sv
// Shared types, constants and tables of the planar odometry integrator.
`default_nettype none
package poi_pkg;

    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int ITER_W           = 5;
    localparam int CW               = 34;   // cordic x/y and sin/cos
    localparam int ZW               = 33;   // cordic residual angle
    localparam int MBW              = 17;   // multiplier b operand
    localparam int PW               = CW + MBW;
    localparam int AW               = 48;   // rotated velocity accumulators

    localparam logic signed [CW-1:0] CORDIC_GAIN   = 34'sd652032874;
    localparam logic signed [31:0]   RESET_X       = -32'sd196608;
    localparam logic signed [31:0]   RESET_Y       = 32'sd196608;
    localparam logic [15:0]          RESET_HEADING = 16'd0;

    localparam logic OPERATION_INTEGRATE = 1'b0;
    localparam logic OPERATION_LOAD      = 1'b1;

    typedef enum logic [1:0] {
        CFG_START_X       = 2'd0,
        CFG_START_Y       = 2'd1,
        CFG_START_HEADING = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_LATCH,
        OP_ROTATE,
        OP_QUADRANT,
        OP_MUL_XC,
        OP_MUL_YS,
        OP_MUL_XS,
        OP_MUL_YC,
        OP_MUL_TX,
        OP_MUL_TY,
        OP_MUL_WR,
        OP_HEADING,
        OP_CAPTURE
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic [ITER_W-1:0]   iter;
    } dp_cmd_t;

    typedef struct packed {
        logic load_req;
    } dp_status_t;

    typedef struct packed {
        logic               operation;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] turn_rate;
        logic [15:0]        elapsed;
    } req_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        heading;
    } res_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [29:0] atan_turn(input logic [ITER_W-1:0] i);
        logic [29:0] v;
        case (i)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> src/poi_if.sv
// Channel interfaces: pose requests, pose results and register writes.
`default_nettype none
interface poi_req_if;
    import poi_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface poi_res_if;
    import poi_pkg::*;
    logic valid;
    logic ready;
    res_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface poi_cfg_if;
    import poi_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

>>> src/planar_odometry_integrator.sv
// Top level of the planar dead-reckoning odometry integrator.
//
//  channel   role    carries
//  request   sink    operation, vel_x, vel_y, turn_rate, elapsed
//  result    source  pos_x, pos_y, heading
//  cfg       sink    index, wdata (start_x, start_y, start_heading)
//
// An integrate request runs from accept to result through the CORDIC
// iterations, one per cycle, a quadrant fold, seven shared multiplies,
// the heading update and the result capture. A load goes straight to capture.
// Reset restores the default start pose and pose. A stalled result holds
// its register while the next request is already being worked on.
`default_nettype none
module planar_odometry_integrator #(
    parameter int ANGLE_BITS   = poi_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = poi_pkg::CORDIC_STEPS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    poi_req_if.sink    request,
    poi_res_if.source  result,
    poi_cfg_if.sink    cfg
);
    import poi_pkg::*;

    `include "planar_odometry_integrator_macros.svh"

    dp_cmd_t    cmd;
    dp_status_t status;
    res_t       res_data;
    logic       cfg_we;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    poi_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    poi_datapath #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req_data  (request.data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg.index),
        .cfg_wdata (cfg.wdata),
        .res_data  (res_data)
    );

    assign result.data = res_data;

    `POI_ASSERT(a_one_at_a_time, clk, rst_n, request.valid && request.ready |=> !request.ready, "request accepted while busy")
    `POI_ASSERT(a_load_latency, clk, rst_n, request.valid && request.ready && request.data.operation && !result.valid |=> ##1 result.valid, "load result late")
    `POI_ASSERT(a_no_early_result, clk, rst_n, request.valid && request.ready && !request.data.operation && !result.valid |=> !result.valid, "integrate result too early")
    `POI_ASSERT_NORST(a_reset_idle, clk, !rst_n |=> !result.valid && request.ready, "not idle after reset")

endmodule
`default_nettype wire

>>> src/poi_ctrl.sv
// Sequencing controller: CORDIC iteration count and multiply schedule.
`default_nettype none
module poi_ctrl #(
    parameter int CORDIC_STEPS = poi_pkg::CORDIC_STEPS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  poi_pkg::dp_status_t  status,
    output poi_pkg::dp_cmd_t     cmd
);
    import poi_pkg::*;

    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_STEPS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROT,
        S_QUAD,
        S_MXC,
        S_MYS,
        S_MXS,
        S_MYC,
        S_MTX,
        S_MTY,
        S_MWR,
        S_HEAD,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = OP_NONE;
        cmd.iter       = iter_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.load_req)
                    begin
                        cmd.op     = OP_LOAD;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.op     = OP_LATCH;
                        iter_next  = '0;
                        state_next = S_ROT;
                    end
                end
            end
            S_ROT:
            begin
                cmd.op = OP_ROTATE;
                if (iter_reg == LAST_ITER)
                begin
                    state_next = S_QUAD;
                end
                else
                begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            S_QUAD:
            begin
                cmd.op     = OP_QUADRANT;
                state_next = S_MXC;
            end
            S_MXC:
            begin
                cmd.op     = OP_MUL_XC;
                state_next = S_MYS;
            end
            S_MYS:
            begin
                cmd.op     = OP_MUL_YS;
                state_next = S_MXS;
            end
            S_MXS:
            begin
                cmd.op     = OP_MUL_XS;
                state_next = S_MYC;
            end
            S_MYC:
            begin
                cmd.op     = OP_MUL_YC;
                state_next = S_MTX;
            end
            S_MTX:
            begin
                cmd.op     = OP_MUL_TX;
                state_next = S_MTY;
            end
            S_MTY:
            begin
                cmd.op     = OP_MUL_TY;
                state_next = S_MWR;
            end
            S_MWR:
            begin
                cmd.op     = OP_MUL_WR;
                state_next = S_HEAD;
            end
            S_HEAD:
            begin
                cmd.op     = OP_HEADING;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_CAPTURE;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

>>> src/poi_datapath.sv
// Datapath: pose and start registers, CORDIC unit, shared multiplier.
`default_nettype none
module poi_datapath #(
    parameter int ANGLE_BITS = poi_pkg::ANGLE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  poi_pkg::dp_cmd_t    cmd,
    output poi_pkg::dp_status_t status,
    input  poi_pkg::req_t       req_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_wdata,
    output poi_pkg::res_t       res_data
);
    import poi_pkg::*;

    localparam int HSHIFT = 28 - ANGLE_BITS;

    // start pose and pose
    logic signed [31:0]       start_x_reg, start_y_reg;
    logic [15:0]              start_h_reg;
    logic signed [31:0]       x_reg, y_reg;
    logic [ANGLE_BITS-1:0]    heading_reg;

    // working registers
    logic signed [15:0]       vx_reg, vy_reg, wr_reg;
    logic [15:0]              dt_reg;
    logic [1:0]               quad_reg;
    logic signed [CW-1:0]     cx_reg, cy_reg, c_reg, s_reg;
    logic signed [ZW-1:0]     z_reg;
    logic signed [PW-1:0]     prod_reg;
    logic signed [AW-1:0]     accx_reg, accy_reg;
    res_t                     res_reg;

    logic [ANGLE_BITS+15:0]   start_h_wide;
    logic [ANGLE_BITS-1:0]    start_h_scaled;
    logic [ANGLE_BITS+15:0]   heading_wide;
    logic [31:0]              a32, round_sum, resid;
    logic [1:0]               quad_next;
    logic signed [ZW-1:0]     z_init;
    logic signed [CW-1:0]     cx_shift, cy_shift;
    logic signed [ZW-1:0]     atan_z;
    logic signed [CW-1:0]     cx_next, cy_next, c_next, s_next;
    logic signed [ZW-1:0]     z_next;
    logic signed [CW-1:0]     mul_a;
    logic signed [MBW-1:0]    mul_b;
    logic signed [PW-1:0]     product;
    logic signed [26:0]       delta;
    logic signed [32:0]       x_sum, y_sum;
    logic signed [31:0]       x_next, y_next;
    logic signed [PW-1:0]     dh_full;
    logic [ANGLE_BITS-1:0]    heading_next;

    assign status.load_req = (req_data.operation == OPERATION_LOAD);

    // heading scaling between 16 bits and ANGLE_BITS
    assign start_h_wide   = {start_h_reg, ANGLE_BITS'(0)};
    assign start_h_scaled = start_h_wide[ANGLE_BITS+15:16];
    assign heading_wide   = {heading_reg, 16'd0};

    // quadrant split: nearest quarter turn plus residual
    assign a32       = {heading_reg, {(32-ANGLE_BITS){1'b0}}};
    assign round_sum = a32 + 32'h2000_0000;
    assign quad_next = round_sum[31:30];
    assign resid     = a32 - {quad_next, 30'd0};
    assign z_init    = {resid[31], resid};

    // one CORDIC rotation
    assign cx_shift = cx_reg >>> cmd.iter;
    assign cy_shift = cy_reg >>> cmd.iter;
    assign atan_z   = {3'b000, atan_turn(cmd.iter)};

    always_comb
    begin
        if (!z_reg[ZW-1])
        begin
            cx_next = cx_reg - cy_shift;
            cy_next = cy_reg + cx_shift;
            z_next  = z_reg - atan_z;
        end
        else
        begin
            cx_next = cx_reg + cy_shift;
            cy_next = cy_reg - cx_shift;
            z_next  = z_reg + atan_z;
        end
    end

    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                c_next = cx_reg;
                s_next = cy_reg;
            end
            2'd1:
            begin
                c_next = -cy_reg;
                s_next = cx_reg;
            end
            2'd2:
            begin
                c_next = -cx_reg;
                s_next = -cy_reg;
            end
            default:
            begin
                c_next = cy_reg;
                s_next = -cx_reg;
            end
        endcase
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_MUL_XC:
            begin
                mul_a = c_reg;
                mul_b = {vx_reg[15], vx_reg};
            end
            OP_MUL_YS:
            begin
                mul_a = s_reg;
                mul_b = {vy_reg[15], vy_reg};
            end
            OP_MUL_XS:
            begin
                mul_a = s_reg;
                mul_b = {vx_reg[15], vx_reg};
            end
            OP_MUL_YC:
            begin
                mul_a = c_reg;
                mul_b = {vy_reg[15], vy_reg};
            end
            OP_MUL_TX:
            begin
                mul_a = accx_reg[CW+13:14];
                mul_b = {1'b0, dt_reg};
            end
            OP_MUL_TY:
            begin
                mul_a = accy_reg[CW+13:14];
                mul_b = {1'b0, dt_reg};
            end
            OP_MUL_WR:
            begin
                mul_a = {{(CW-16){wr_reg[15]}}, wr_reg};
                mul_b = {1'b0, dt_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    // position update with saturation
    assign delta = prod_reg[PW-1:24];
    assign x_sum = {x_reg[31], x_reg} + {{6{delta[26]}}, delta};
    assign y_sum = {y_reg[31], y_reg} + {{6{delta[26]}}, delta};

    always_comb
    begin
        if (x_sum[32] != x_sum[31])
        begin
            x_next = x_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            x_next = x_sum[31:0];
        end
        if (y_sum[32] != y_sum[31])
        begin
            y_next = y_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            y_next = y_sum[31:0];
        end
    end

    assign dh_full      = prod_reg >>> HSHIFT;
    assign heading_next = heading_reg + dh_full[ANGLE_BITS-1:0];

    // configuration and pose state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= RESET_X;
            start_y_reg <= RESET_Y;
            start_h_reg <= RESET_HEADING;
            x_reg       <= RESET_X;
            y_reg       <= RESET_Y;
            heading_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_START_X:       start_x_reg <= cfg_wdata;
                    CFG_START_Y:       start_y_reg <= cfg_wdata;
                    CFG_START_HEADING: start_h_reg <= cfg_wdata[15:0];
                    default:           ;
                endcase
            end
            unique case (cmd.op)
                OP_LOAD:
                begin
                    x_reg       <= start_x_reg;
                    y_reg       <= start_y_reg;
                    heading_reg <= start_h_scaled;
                end
                OP_MUL_TY:  x_reg       <= x_next;
                OP_MUL_WR:  y_reg       <= y_next;
                OP_HEADING: heading_reg <= heading_next;
                default:    ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op) inside
            OP_LATCH:
            begin
                vx_reg   <= req_data.vel_x;
                vy_reg   <= req_data.vel_y;
                wr_reg   <= req_data.turn_rate;
                dt_reg   <= req_data.elapsed;
                quad_reg <= quad_next;
                cx_reg   <= CORDIC_GAIN;
                cy_reg   <= '0;
                z_reg    <= z_init;
            end
            OP_ROTATE:
            begin
                cx_reg <= cx_next;
                cy_reg <= cy_next;
                z_reg  <= z_next;
            end
            OP_QUADRANT:
            begin
                c_reg <= c_next;
                s_reg <= s_next;
            end
            OP_MUL_XC:
            begin
                prod_reg <= product;
            end
            OP_MUL_YS:
            begin
                prod_reg <= product;
                accx_reg <= prod_reg[AW-1:0];
            end
            OP_MUL_XS:
            begin
                prod_reg <= product;
                accx_reg <= accx_reg - prod_reg[AW-1:0];
            end
            OP_MUL_YC:
            begin
                prod_reg <= product;
                accy_reg <= prod_reg[AW-1:0];
            end
            OP_MUL_TX:
            begin
                prod_reg <= product;
                accy_reg <= accy_reg + prod_reg[AW-1:0];
            end
            OP_MUL_TY, OP_MUL_WR:
            begin
                prod_reg <= product;
            end
            OP_CAPTURE:
            begin
                res_reg.pos_x   <= x_reg;
                res_reg.pos_y   <= y_reg;
                res_reg.heading <= heading_wide[ANGLE_BITS+15:ANGLE_BITS];
            end
            default: ;
        endcase
    end

    assign res_data = res_reg;

endmodule
`default_nettype wire
